// File: rtl/lcdnw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Types, request codes and character constants for the character LCD
// number writer.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

    // request modes
    localparam logic [2:0] MODE_INIT   = 3'd0;
    localparam logic [2:0] MODE_CHAR   = 3'd1;
    localparam logic [2:0] MODE_UDEC   = 3'd2;
    localparam logic [2:0] MODE_SDEC   = 3'd3;
    localparam logic [2:0] MODE_HEX    = 3'd4;
    localparam logic [2:0] MODE_BIN    = 3'd5;

    // display command and character constants
    localparam logic [7:0] CMD_FUNC_SET  = 8'h38;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CURSOR_BASE   = 8'h80;
    localparam logic [7:0] LINE2_OFFSET  = 8'h40;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_PLUS     = 8'h2B;
    localparam logic [7:0] CHAR_MINUS    = 8'h2D;
    localparam logic [1:0] LINE_FIRST    = 2'd1;

    // x / 10 == (x * RECIP10) >> RECIP10_SHIFT for every 16-bit x
    localparam logic [15:0] RECIP10       = 16'd52429;
    localparam int          RECIP10_SHIFT = 19;

    // request fields
    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  line;
        logic [5:0]  column;
        logic [15:0] value;
        logic [4:0]  digit_count;
        logic [7:0]  char_code;
    } req_t;

    // one bus write
    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } wr_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_EXTRACT,
        ST_CURSOR,
        ST_CHAR,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    // fixed setup command by position
    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] cmd;
        case (idx)
            2'd0:    cmd = CMD_FUNC_SET;
            2'd1:    cmd = CMD_DISP_ON;
            2'd2:    cmd = CMD_ENTRY;
            default: cmd = CMD_CLEAR;
        endcase
        return cmd;
    endfunction

    // digit value to ascii, uppercase for ten and above
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] ch;
        if (d < 4'd10)
            ch = CHAR_ZERO + {4'd0, d};
        else
            ch = CHAR_UPPER_A + {4'd0, d} - 8'd10;
        return ch;
    endfunction

endpackage

// File: rtl/char_lcd_number_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_number_writer
// Turns one display request into the ordered list of character LCD bus
// writes: setup commands, or a cursor command then a character or a number.
// ----------------------------------------------------------------------------
//  port      dir   handshake               carries
//  req       in    req_valid / req_ready   one display request (req_t)
//  wr        out   wr_valid  / wr_ready    one bus write (wr_t)
//
//  A request is taken, then one digit a cycle is extracted by a shared
//  divide-by-base step, then one write a cycle leaves while wr_ready is
//  high: init gives four commands, char the cursor command and the
//  character, a number the cursor command, a sign for signed decimal and
//  N digits (N = saturated digit count). Output stalls hold the write states.
//  Reset empties the output register and returns the sequencer to idle.
//  Modes six and seven are taken and give no writes.
// ----------------------------------------------------------------------------
module char_lcd_number_writer #(
    parameter int MAX_DIGITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  lcdnw_pkg::req_t  req,
    output logic             wr_valid,
    input  logic             wr_ready,
    output lcdnw_pkg::wr_t   wr
);
    import lcdnw_pkg::*;

    localparam int         BUF_W   = 4 * MAX_DIGITS;
    localparam logic [4:0] MAX_CNT = 5'(MAX_DIGITS);

    state_t             state_reg, state_next;
    logic [2:0]         mode_reg, mode_next;
    logic [7:0]         cursor_reg, cursor_next;
    logic [7:0]         char_reg, char_next;
    logic               neg_reg, neg_next;
    logic [15:0]        mag_reg, mag_next;
    logic [4:0]         count_reg, count_next;
    logic [4:0]         rem_reg, rem_next;
    logic [1:0]         idx_reg, idx_next;
    logic [BUF_W-1:0]   buf_reg, buf_next;
    logic               wr_valid_reg, wr_valid_next;
    wr_t                wr_reg, wr_next;

    logic               accept;
    logic               out_free;
    logic               out_load;
    logic [4:0]         cnt_sat;
    logic [7:0]         col_sum;
    logic [31:0]        prod;
    logic [15:0]        quot10;
    logic [15:0]        rem10;
    logic [3:0]         digit;
    logic [15:0]        mag_shift;

    assign accept   = req_valid && req_ready;
    assign out_free = !wr_valid_reg || wr_ready;
    assign wr_valid = wr_valid_reg;
    assign wr       = wr_reg;

    // saturated digit count and cursor address of the incoming request
    assign cnt_sat = (req.digit_count > MAX_CNT) ? MAX_CNT : req.digit_count;
    assign col_sum = {2'b00, req.column} + 8'hFF
                     + ((req.line == LINE_FIRST) ? 8'h00 : LINE2_OFFSET);

    // shared digit step: divide by the mode's base, keep the remainder
    assign prod   = mag_reg * RECIP10;
    assign quot10 = 16'(prod[31:RECIP10_SHIFT]);
    assign rem10  = mag_reg - ((quot10 << 3) + (quot10 << 1));

    always_comb
    begin
        case (mode_reg)
            MODE_HEX:
            begin
                digit     = mag_reg[3:0];
                mag_shift = mag_reg >> 4;
            end
            MODE_BIN:
            begin
                digit     = {3'b000, mag_reg[0]};
                mag_shift = mag_reg >> 1;
            end
            default:
            begin
                digit     = rem10[3:0];
                mag_shift = quot10;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.mode)
                        MODE_INIT: state_next = ST_INIT;
                        MODE_CHAR: state_next = ST_CURSOR;
                        MODE_UDEC,
                        MODE_SDEC,
                        MODE_HEX,
                        MODE_BIN:  state_next = ST_EXTRACT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT:
            begin
                if (out_free && idx_reg == 2'd3)
                    state_next = ST_IDLE;
            end
            ST_EXTRACT:
            begin
                if (rem_reg == 5'd0)
                    state_next = ST_CURSOR;
            end
            ST_CURSOR:
            begin
                if (out_free)
                begin
                    if (mode_reg == MODE_CHAR)
                        state_next = ST_CHAR;
                    else if (mode_reg == MODE_SDEC)
                        state_next = ST_SIGN;
                    else if (count_reg == 5'd0)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_DIGIT;
                end
            end
            ST_CHAR:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_SIGN:
            begin
                if (out_free)
                    state_next = (count_reg == 5'd0) ? ST_IDLE : ST_DIGIT;
            end
            ST_DIGIT:
            begin
                if (out_free && rem_reg == 5'd1)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: ready and the bus write loaded into the output register
    always_comb
    begin
        req_ready = 1'b0;
        out_load  = 1'b0;
        wr_next   = wr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_INIT:
            begin
                out_load = out_free;
                wr_next  = '{is_data: 1'b0, bus_byte: init_cmd(idx_reg),
                             last: (idx_reg == 2'd3)};
            end
            ST_CURSOR:
            begin
                out_load = out_free;
                wr_next  = '{is_data: 1'b0, bus_byte: cursor_reg,
                             last: (mode_reg != MODE_CHAR) && (mode_reg != MODE_SDEC)
                                   && (count_reg == 5'd0)};
            end
            ST_CHAR:
            begin
                out_load = out_free;
                wr_next  = '{is_data: 1'b1, bus_byte: char_reg, last: 1'b1};
            end
            ST_SIGN:
            begin
                out_load = out_free;
                wr_next  = '{is_data: 1'b1,
                             bus_byte: neg_reg ? CHAR_MINUS : CHAR_PLUS,
                             last: (count_reg == 5'd0)};
            end
            ST_DIGIT:
            begin
                out_load = out_free;
                wr_next  = '{is_data: 1'b1,
                             bus_byte: digit_char(buf_reg[BUF_W-1 -: 4]),
                             last: (rem_reg == 5'd1)};
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        mode_next     = mode_reg;
        cursor_next   = cursor_reg;
        char_next     = char_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        count_next    = count_reg;
        rem_next      = rem_reg;
        idx_next      = idx_reg;
        buf_next      = buf_reg;
        wr_valid_next = out_load ? 1'b1 : (wr_ready ? 1'b0 : wr_valid_reg);

        if (accept)
        begin
            mode_next   = req.mode;
            cursor_next = CURSOR_BASE | col_sum;
            char_next   = req.char_code;
            neg_next    = req.value[15];
            mag_next    = (req.mode == MODE_SDEC && req.value[15]) ? (16'd0 - req.value)
                                                                    : req.value;
            count_next  = cnt_sat;
            rem_next    = cnt_sat;
            idx_next    = 2'd0;
        end

        // digits go in least significant first at the top, so the top nibble
        // ends up holding the most significant digit
        if (state_reg == ST_EXTRACT)
        begin
            if (rem_reg == 5'd0)
            begin
                rem_next = count_reg;
            end
            else
            begin
                buf_next = {digit, buf_reg[BUF_W-1:4]};
                mag_next = mag_shift;
                rem_next = rem_reg - 5'd1;
            end
        end

        if (out_load && state_reg == ST_INIT)
            idx_next = idx_reg + 2'd1;

        if (out_load && state_reg == ST_DIGIT)
        begin
            buf_next = buf_reg << 4;
            rem_next = rem_reg - 5'd1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wr_valid_reg <= 1'b0;
            rem_reg      <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            wr_valid_reg <= wr_valid_next;
            rem_reg      <= rem_next;
            idx_reg      <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        cursor_reg <= cursor_next;
        char_reg   <= char_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        count_reg  <= count_next;
        buf_reg    <= buf_next;
        if (out_load)
            wr_reg <= wr_next;
    end

    // a valid request mode keeps the block busy on the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.mode <= MODE_BIN) |=> !req_ready)
        else $error("ready high right after a valid request");

    // a write still pending while idle must be the end of its request
    a_idle_pending_last: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_valid && state_reg == ST_IDLE) |-> wr.last)
        else $error("pending write while idle is not the last one");

    // the digit counter never passes the saturated count
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= MAX_CNT)
        else $error("digit counter out of range");

    // every digit write is a data write
    a_digit_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && state_reg == ST_DIGIT) |=> (wr_valid && wr.is_data))
        else $error("digit write not marked as data");

endmodule
